// ===== hdl/flc_pkg.sv =====
// Shared constants, register indexes and sequencer states for the finish line lap counter.
// No dependencies; every other file takes names from here by scope.
package flc_pkg;

   localparam int POS_BITS_DEFAULT = 24;

   localparam int CFG_ADDR_BITS = 5;
   localparam int CFG_DATA_BITS = 32;
   localparam int FINISH_BITS   = 24;
   localparam int RADIUS_BITS   = 23;
   localparam int COS_BITS      = 16;
   localparam int LAP_BITS      = 16;

   localparam logic [RADIUS_BITS-1:0] NEAR_RADIUS_RESET  = 23'd1280;
   localparam logic [COS_BITS-1:0]    COSINE_LIMIT_RESET = 16'd16384;
   localparam logic [LAP_BITS-1:0]    LAP_MAX            = 16'hFFFF;

   // datapath widths
   localparam int MUL_BITS  = 25;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int ACC_BITS  = PROD_BITS + 1;
   localparam int UNIT_BITS = 17;
   localparam int DOT_BITS  = 36;
   localparam int ROOT_BITS = 32;
   localparam int QUO_BITS  = 16;
   localparam int ITER_BITS = 4;

   typedef enum logic [2:0] {
      REG_LEFT_X,
      REG_LEFT_Y,
      REG_RIGHT_X,
      REG_RIGHT_Y,
      REG_NEAR_RADIUS,
      REG_COSINE_LIMIT
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_SQX,
      S_SQY,
      S_SQL,
      S_LOAD,
      S_NORM,
      S_MAGX,
      S_MAGY,
      S_ROOT,
      S_DIVX,
      S_DIVY,
      S_DOTA,
      S_DOTB,
      S_DECIDE,
      S_DONE
   } state_type;

endpackage

// ===== hdl/flc_intf.sv =====
// Valid/ready channel interfaces for positions in and lap results out.
// Depends on flc_pkg for default widths.
interface flc_req_intf #(parameter int POS_BITS = flc_pkg::POS_BITS_DEFAULT);
   logic                       valid;
   logic                       ready;
   logic signed [POS_BITS-1:0] pos_x;
   logic signed [POS_BITS-1:0] pos_y;

   modport source (output valid, output pos_x, output pos_y, input ready);
   modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

interface flc_rsp_intf;
   logic                          valid;
   logic                          ready;
   logic [flc_pkg::LAP_BITS-1:0]  lap_total;
   logic                          lap_crossed;
   logic                          finish_ahead;

   modport source (output valid, output lap_total, output lap_crossed, output finish_ahead,
                   input ready);
   modport sink (input valid, input lap_total, input lap_crossed, input finish_ahead,
                 output ready);
endinterface

// ===== hdl/finish_line_lap_counter.sv =====
// Finish line lap counter: APB register file, sequencer and one shared multiplier,
// square root and divider. Depends on flc_pkg and the channel interfaces in flc_intf.
//
// Use: positions arrive on req_bus (valid/ready), one result per position leaves
// on rsp_bus (lap_total, lap_crossed, finish_ahead). Finish points, near radius and
// cosine limit are written over the APB port, by the user only while idle (the block
// does not enforce it); pready is always high and reads return the register value.
// The first position, a repeated position or one outside the near box goes from the
// range check straight to the result; one inside the box but outside the circle first
// squares the offset and the limit. A position near the finish runs three vector
// normalizations through one multiplier, a 16-step square root and two 16-step
// restoring divisions per vector (a zero vector skips them), then the dot products,
// the decision and the result load; the root and divide give one bit per cycle.
// req_bus.ready is high whenever the sequencer is idle.
// A finished result sits in the output register; the next position may be taken
// while it waits. A new result waits in the done state until rsp_bus.ready frees
// the output register.
// Reset (synchronous, active high) clears the count, the ahead flag and the
// stored position, and returns the registers to their reset values.
module finish_line_lap_counter #(
   parameter int POS_BITS = flc_pkg::POS_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   flc_req_intf.sink                          req_bus,
   flc_rsp_intf.source                        rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [flc_pkg::CFG_ADDR_BITS-1:0]  paddr,
   input  logic [flc_pkg::CFG_DATA_BITS-1:0]  pwdata,
   output logic [flc_pkg::CFG_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   localparam int DW = (POS_BITS + 2 > 26) ? POS_BITS + 2 : 26;
   localparam int FB = flc_pkg::FINISH_BITS;
   localparam int MB = flc_pkg::MUL_BITS;
   localparam int AB = flc_pkg::ACC_BITS;
   localparam int UB = flc_pkg::UNIT_BITS;
   localparam int OB = flc_pkg::DOT_BITS;
   localparam int RB = flc_pkg::ROOT_BITS;
   localparam int QB = flc_pkg::QUO_BITS;
   localparam int IB = flc_pkg::ITER_BITS;
   localparam int LB = flc_pkg::LAP_BITS;
   localparam int CB = flc_pkg::COS_BITS;
   localparam int NB = flc_pkg::RADIUS_BITS;
   localparam int CDB = flc_pkg::CFG_DATA_BITS;

   function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
      mag_of = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   // configuration
   logic signed [FB-1:0] left_x_ff, left_y_ff, right_x_ff, right_y_ff;
   logic [NB-1:0]        near_ff;
   logic signed [CB-1:0] cos_ff;

   // control and item state
   flc_pkg::state_type         state_ff, state_in;
   logic signed [POS_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [POS_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                       prev_valid_ff, prev_valid_in;
   logic                       ahead_ff, ahead_in;
   logic [LB-1:0]              lap_ff, lap_in;
   logic                       crossed_ff, crossed_in;

   // datapath
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DW-1:0]        adx_ff, adx_in, ady_ff, ady_in;
   logic signed [AB-1:0] acc_ff, acc_in;
   logic [1:0]           vi_ff, vi_in, di_ff, di_in;
   logic [IB-1:0]        cnt_ff, cnt_in;
   logic [DW-1:0]        nx_ff, nx_in, ny_ff, ny_in;
   logic                 sx_ff, sx_in, sy_ff, sy_in;
   logic [RB-1:0]        rt_n_ff, rt_n_in, rt_res_ff, rt_res_in, rt_bit_ff, rt_bit_in;
   logic [QB-1:0]        rem_ff, rem_in, dvd_ff, dvd_in, quo_ff, quo_in;
   logic signed [UB-1:0] u1x_ff, u1x_in, u1y_ff, u1y_in;
   logic signed [UB-1:0] u2x_ff, u2x_in, u2y_ff, u2y_in;
   logic signed [UB-1:0] u3x_ff, u3x_in, u3y_ff, u3y_in;
   logic signed [OB-1:0] d12_ff, d12_in, d23_ff, d23_in, d31_ff, d31_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0] rsp_lap_ff, rsp_lap_in;
   logic          rsp_crossed_ff, rsp_crossed_in;
   logic          rsp_ahead_ff, rsp_ahead_in;

   // shared and combinational helpers
   logic signed [MB-1:0]   mul_a, mul_b;
   logic signed [2*MB-1:0] mul_p;
   logic signed [AB-1:0]   sum_p;
   logic [FB-1:0]          lim;
   logic signed [DW-1:0]   chk_dx, chk_dy, vec_x, vec_y;
   logic [DW-1:0]          chk_adx, chk_ady;
   logic                   same_pos, far_box, vec_zero, too_big, too_small;
   logic [RB-1:0]          rt_try;
   logic                   rt_ge;
   logic [QB:0]            div_t, div_r, div_rem;
   logic                   div_ge;
   logic [QB-1:0]          quo_next;
   logic signed [UB-1:0]   q_pos, q_x, q_y;
   logic signed [UB-1:0]   dot_ax, dot_ay, dot_bx, dot_by;
   logic signed [OB-1:0]   th, neg_th;
   logic                   cfg_write, rsp_free;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign lim       = {near_ff, 1'b0};
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff  <= '0;
         left_y_ff  <= '0;
         right_x_ff <= '0;
         right_y_ff <= '0;
         near_ff    <= flc_pkg::NEAR_RADIUS_RESET;
         cos_ff     <= flc_pkg::COSINE_LIMIT_RESET;
      end else if (cfg_write) begin
         unique case (paddr[4:2])
            flc_pkg::REG_LEFT_X:       left_x_ff  <= pwdata[FB-1:0];
            flc_pkg::REG_LEFT_Y:       left_y_ff  <= pwdata[FB-1:0];
            flc_pkg::REG_RIGHT_X:      right_x_ff <= pwdata[FB-1:0];
            flc_pkg::REG_RIGHT_Y:      right_y_ff <= pwdata[FB-1:0];
            flc_pkg::REG_NEAR_RADIUS:  near_ff    <= pwdata[NB-1:0];
            flc_pkg::REG_COSINE_LIMIT: cos_ff     <= pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         flc_pkg::REG_LEFT_X:       prdata = CDB'({left_x_ff});
         flc_pkg::REG_LEFT_Y:       prdata = CDB'({left_y_ff});
         flc_pkg::REG_RIGHT_X:      prdata = CDB'({right_x_ff});
         flc_pkg::REG_RIGHT_Y:      prdata = CDB'({right_y_ff});
         flc_pkg::REG_NEAR_RADIUS:  prdata = CDB'(near_ff);
         flc_pkg::REG_COSINE_LIMIT: prdata = CDB'({cos_ff});
         default:                   prdata = '0;
      endcase
   end

   // ---------------- shared arithmetic ----------------
   always_comb begin
      unique case (di_ff)
         2'd1: begin
            dot_ax = u2x_ff; dot_ay = u2y_ff; dot_bx = u3x_ff; dot_by = u3y_ff;
         end
         2'd2: begin
            dot_ax = u3x_ff; dot_ay = u3y_ff; dot_bx = u1x_ff; dot_by = u1y_ff;
         end
         default: begin
            dot_ax = u1x_ff; dot_ay = u1y_ff; dot_bx = u2x_ff; dot_by = u2y_ff;
         end
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         flc_pkg::S_SQX: begin
            mul_a = {1'b0, adx_ff[FB-1:0]}; mul_b = {1'b0, adx_ff[FB-1:0]};
         end
         flc_pkg::S_SQY: begin
            mul_a = {1'b0, ady_ff[FB-1:0]}; mul_b = {1'b0, ady_ff[FB-1:0]};
         end
         flc_pkg::S_SQL: begin
            mul_a = {1'b0, lim}; mul_b = {1'b0, lim};
         end
         flc_pkg::S_MAGX: begin
            mul_a = {10'd0, nx_ff[14:0]}; mul_b = {10'd0, nx_ff[14:0]};
         end
         flc_pkg::S_MAGY: begin
            mul_a = {10'd0, ny_ff[14:0]}; mul_b = {10'd0, ny_ff[14:0]};
         end
         flc_pkg::S_DOTA: begin
            mul_a = MB'(dot_ax); mul_b = MB'(dot_bx);
         end
         flc_pkg::S_DOTB: begin
            mul_a = MB'(dot_ay); mul_b = MB'(dot_by);
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign sum_p = acc_ff + AB'(mul_p);

   // doubled offset from the finish centre
   assign chk_dx = {{(DW-POS_BITS-1){pos_x_ff[POS_BITS-1]}}, pos_x_ff, 1'b0}
                   - ({{(DW-FB){left_x_ff[FB-1]}}, left_x_ff}
                      + {{(DW-FB){right_x_ff[FB-1]}}, right_x_ff});
   assign chk_dy = {{(DW-POS_BITS-1){pos_y_ff[POS_BITS-1]}}, pos_y_ff, 1'b0}
                   - ({{(DW-FB){left_y_ff[FB-1]}}, left_y_ff}
                      + {{(DW-FB){right_y_ff[FB-1]}}, right_y_ff});
   assign chk_adx  = mag_of(chk_dx);
   assign chk_ady  = mag_of(chk_dy);
   assign far_box  = (chk_adx > DW'(lim)) || (chk_ady > DW'(lim));
   assign same_pos = (pos_x_ff == prev_x_ff) && (pos_y_ff == prev_y_ff);

   // vector to normalize: motion, finish normal, offset from centre
   always_comb begin
      unique case (vi_ff)
         2'd0: begin
            vec_x = {{(DW-POS_BITS){prev_x_ff[POS_BITS-1]}}, prev_x_ff}
                    - {{(DW-POS_BITS){pos_x_ff[POS_BITS-1]}}, pos_x_ff};
            vec_y = {{(DW-POS_BITS){prev_y_ff[POS_BITS-1]}}, prev_y_ff}
                    - {{(DW-POS_BITS){pos_y_ff[POS_BITS-1]}}, pos_y_ff};
         end
         2'd1: begin
            vec_x = {{(DW-FB){right_y_ff[FB-1]}}, right_y_ff}
                    - {{(DW-FB){left_y_ff[FB-1]}}, left_y_ff};
            vec_y = {{(DW-FB){left_x_ff[FB-1]}}, left_x_ff}
                    - {{(DW-FB){right_x_ff[FB-1]}}, right_x_ff};
         end
         default: begin
            vec_x = dx_ff;
            vec_y = dy_ff;
         end
      endcase
   end

   assign vec_zero  = (vec_x == '0) && (vec_y == '0);
   assign too_big   = (|nx_ff[DW-1:15]) || (|ny_ff[DW-1:15]);
   assign too_small = !(|nx_ff[DW-1:14]) && !(|ny_ff[DW-1:14]);

   // square root, one result bit per cycle
   assign rt_try = rt_res_ff + rt_bit_ff;
   assign rt_ge  = rt_n_ff >= rt_try;

   // restoring divide by the root, one quotient bit per cycle
   assign div_t    = {rem_ff, dvd_ff[QB-1]};
   assign div_r    = {1'b0, rt_res_ff[QB-1:0]};
   assign div_ge   = div_t >= div_r;
   assign div_rem  = div_ge ? div_t - div_r : div_t;
   assign quo_next = {quo_ff[QB-2:0], div_ge};
   assign q_pos    = {1'b0, quo_next};
   assign q_x      = sx_ff ? -q_pos : q_pos;
   assign q_y      = sy_ff ? -q_pos : q_pos;

   assign th     = {{(OB-CB-15){cos_ff[CB-1]}}, cos_ff, 15'd0};
   assign neg_th = -th;

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flc_pkg::S_IDLE:  if (req_bus.valid) state_in = flc_pkg::S_CHECK;
         flc_pkg::S_CHECK: begin
            if (!prev_valid_ff || same_pos || far_box) state_in = flc_pkg::S_DONE;
            else state_in = flc_pkg::S_SQX;
         end
         flc_pkg::S_SQX:   state_in = flc_pkg::S_SQY;
         flc_pkg::S_SQY:   state_in = flc_pkg::S_SQL;
         flc_pkg::S_SQL: begin
            if (acc_ff <= AB'(mul_p)) state_in = flc_pkg::S_LOAD;
            else state_in = flc_pkg::S_DONE;
         end
         flc_pkg::S_LOAD: begin
            if (!vec_zero) state_in = flc_pkg::S_NORM;
            else if (vi_ff == 2'd2) state_in = flc_pkg::S_DOTA;
         end
         flc_pkg::S_NORM:  if (!too_big && !too_small) state_in = flc_pkg::S_MAGX;
         flc_pkg::S_MAGX:  state_in = flc_pkg::S_MAGY;
         flc_pkg::S_MAGY:  state_in = flc_pkg::S_ROOT;
         flc_pkg::S_ROOT:  if (&cnt_ff) state_in = flc_pkg::S_DIVX;
         flc_pkg::S_DIVX:  if (&cnt_ff) state_in = flc_pkg::S_DIVY;
         flc_pkg::S_DIVY: begin
            if (&cnt_ff) begin
               state_in = (vi_ff == 2'd2) ? flc_pkg::S_DOTA : flc_pkg::S_LOAD;
            end
         end
         flc_pkg::S_DOTA:  state_in = flc_pkg::S_DOTB;
         flc_pkg::S_DOTB: begin
            state_in = (di_ff == 2'd2) ? flc_pkg::S_DECIDE : flc_pkg::S_DOTA;
         end
         flc_pkg::S_DECIDE: state_in = flc_pkg::S_DONE;
         flc_pkg::S_DONE:   if (rsp_free) state_in = flc_pkg::S_IDLE;
         default:           state_in = flc_pkg::S_IDLE;
      endcase
   end

   // ---------------- sequencer: datapath and outputs ----------------
   always_comb begin
      req_bus.ready = (state_ff == flc_pkg::S_IDLE);

      pos_x_in = pos_x_ff;   pos_y_in = pos_y_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      prev_valid_in = prev_valid_ff;
      ahead_in = ahead_ff;   lap_in = lap_ff;   crossed_in = crossed_ff;
      dx_in = dx_ff;   dy_in = dy_ff;   adx_in = adx_ff;   ady_in = ady_ff;
      acc_in = acc_ff; vi_in = vi_ff;   di_in = di_ff;     cnt_in = cnt_ff;
      nx_in = nx_ff;   ny_in = ny_ff;   sx_in = sx_ff;     sy_in = sy_ff;
      rt_n_in = rt_n_ff; rt_res_in = rt_res_ff; rt_bit_in = rt_bit_ff;
      rem_in = rem_ff; dvd_in = dvd_ff; quo_in = quo_ff;
      u1x_in = u1x_ff; u1y_in = u1y_ff; u2x_in = u2x_ff; u2y_in = u2y_ff;
      u3x_in = u3x_ff; u3y_in = u3y_ff;
      d12_in = d12_ff; d23_in = d23_ff; d31_in = d31_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_lap_in = rsp_lap_ff; rsp_crossed_in = rsp_crossed_ff; rsp_ahead_in = rsp_ahead_ff;

      unique case (state_ff)
         flc_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               pos_x_in   = req_bus.pos_x;
               pos_y_in   = req_bus.pos_y;
               crossed_in = 1'b0;
            end
         end
         flc_pkg::S_CHECK: begin
            dx_in  = chk_dx;  dy_in  = chk_dy;
            adx_in = chk_adx; ady_in = chk_ady;
         end
         flc_pkg::S_SQX: acc_in = AB'(mul_p);
         flc_pkg::S_SQY: acc_in = sum_p;
         flc_pkg::S_SQL: begin
            vi_in = 2'd0;
            di_in = 2'd0;
         end
         flc_pkg::S_LOAD: begin
            nx_in = mag_of(vec_x); ny_in = mag_of(vec_y);
            sx_in = vec_x[DW-1];   sy_in = vec_y[DW-1];
            if (vec_zero) begin
               unique case (vi_ff)
                  2'd0:    begin u1x_in = '0; u1y_in = '0; end
                  2'd1:    begin u2x_in = '0; u2y_in = '0; end
                  default: begin u3x_in = '0; u3y_in = '0; end
               endcase
               vi_in = vi_ff + 2'd1;
            end
         end
         flc_pkg::S_NORM: begin
            // shift both magnitudes together until the larger is in [2^14, 2^15)
            if (too_big) begin
               nx_in = nx_ff >> 1; ny_in = ny_ff >> 1;
            end else if (too_small) begin
               nx_in = nx_ff << 1; ny_in = ny_ff << 1;
            end
         end
         flc_pkg::S_MAGX: acc_in = AB'(mul_p);
         flc_pkg::S_MAGY: begin
            rt_n_in   = sum_p[RB-1:0];
            rt_res_in = '0;
            rt_bit_in = RB'(1) << (RB - 2);
            cnt_in    = '0;
         end
         flc_pkg::S_ROOT: begin
            if (rt_ge) begin
               rt_n_in   = rt_n_ff - rt_try;
               rt_res_in = (rt_res_ff >> 1) + rt_bit_ff;
            end else begin
               rt_res_in = rt_res_ff >> 1;
            end
            rt_bit_in = rt_bit_ff >> 2;
            cnt_in    = cnt_ff + IB'(1);
            if (&cnt_ff) begin
               rem_in = {2'd0, nx_ff[14:1]};
               dvd_in = {nx_ff[0], 15'd0};
               quo_in = '0;
            end
         end
         flc_pkg::S_DIVX: begin
            rem_in = div_rem[QB-1:0];
            dvd_in = dvd_ff << 1;
            quo_in = quo_next;
            cnt_in = cnt_ff + IB'(1);
            if (&cnt_ff) begin
               unique case (vi_ff)
                  2'd0:    u1x_in = q_x;
                  2'd1:    u2x_in = q_x;
                  default: u3x_in = q_x;
               endcase
               rem_in = {2'd0, ny_ff[14:1]};
               dvd_in = {ny_ff[0], 15'd0};
               quo_in = '0;
            end
         end
         flc_pkg::S_DIVY: begin
            rem_in = div_rem[QB-1:0];
            dvd_in = dvd_ff << 1;
            quo_in = quo_next;
            cnt_in = cnt_ff + IB'(1);
            if (&cnt_ff) begin
               unique case (vi_ff)
                  2'd0:    u1y_in = q_y;
                  2'd1:    u2y_in = q_y;
                  default: u3y_in = q_y;
               endcase
               vi_in = vi_ff + 2'd1;
            end
         end
         flc_pkg::S_DOTA: acc_in = AB'(mul_p);
         flc_pkg::S_DOTB: begin
            unique case (di_ff)
               2'd0:    d12_in = sum_p[OB-1:0];
               2'd1:    d23_in = sum_p[OB-1:0];
               default: d31_in = sum_p[OB-1:0];
            endcase
            di_in = di_ff + 2'd1;
         end
         flc_pkg::S_DECIDE: begin
            if (d12_ff > th) begin
               priority if (d23_ff > th && d31_ff > th) begin
                  ahead_in = 1'b1;
               end else if (d23_ff < neg_th && d31_ff < neg_th) begin
                  if (ahead_ff) begin
                     crossed_in = 1'b1;
                     if (lap_ff != flc_pkg::LAP_MAX) lap_in = lap_ff + LB'(1);
                  end
                  ahead_in = 1'b0;
               end else begin
                  ahead_in = 1'b0;
               end
            end
         end
         flc_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_lap_in     = lap_ff;
               rsp_crossed_in = crossed_ff;
               rsp_ahead_in   = ahead_ff;
               prev_x_in      = pos_x_ff;
               prev_y_in      = pos_y_ff;
               prev_valid_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.lap_total    = rsp_lap_ff;
   assign rsp_bus.lap_crossed  = rsp_crossed_ff;
   assign rsp_bus.finish_ahead = rsp_ahead_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= flc_pkg::S_IDLE;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_valid_ff <= 1'b0;
         ahead_ff      <= 1'b0;
         lap_ff        <= '0;
         crossed_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         vi_ff         <= '0;
         di_ff         <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_valid_ff <= prev_valid_in;
         ahead_ff      <= ahead_in;
         lap_ff        <= lap_in;
         crossed_ff    <= crossed_in;
         rsp_valid_ff  <= rsp_valid_in;
         vi_ff         <= vi_in;
         di_ff         <= di_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff <= pos_x_in;  pos_y_ff <= pos_y_in;
      dx_ff <= dx_in;        dy_ff <= dy_in;
      adx_ff <= adx_in;      ady_ff <= ady_in;
      acc_ff <= acc_in;
      nx_ff <= nx_in;        ny_ff <= ny_in;
      sx_ff <= sx_in;        sy_ff <= sy_in;
      rt_n_ff <= rt_n_in;    rt_res_ff <= rt_res_in;   rt_bit_ff <= rt_bit_in;
      rem_ff <= rem_in;      dvd_ff <= dvd_in;         quo_ff <= quo_in;
      u1x_ff <= u1x_in;      u1y_ff <= u1y_in;
      u2x_ff <= u2x_in;      u2y_ff <= u2y_in;
      u3x_ff <= u3x_in;      u3y_ff <= u3y_in;
      d12_ff <= d12_in;      d23_ff <= d23_in;         d31_ff <= d31_in;
      rsp_lap_ff <= rsp_lap_in;
      rsp_crossed_ff <= rsp_crossed_in;
      rsp_ahead_ff <= rsp_ahead_in;
   end

   // ---------------- assertions ----------------
   a_lap_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> lap_ff >= $past(lap_ff))
      else $error("lap count went down");

   a_cross_clears_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_crossed_ff && rsp_ahead_ff))
      else $error("lap counted while finish still ahead");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == flc_pkg::S_MAGX |-> !too_big && !too_small)
      else $error("normalized magnitude out of range");

   a_div_rem_below_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flc_pkg::S_DIVX || state_ff == flc_pkg::S_DIVY)
      |-> {1'b0, rem_ff} < div_r)
      else $error("divider remainder not below root");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == flc_pkg::S_DONE && !rsp_free |=> state_ff == flc_pkg::S_DONE)
      else $error("result dropped while output register busy");

endmodule

// ===== bench/finish_line_lap_counter_test.sv =====
// Self-checking bench for the finish line lap counter: positions on the request channel,
// lap results on the response channel, finish geometry over the APB register port.
// Depends on flc_pkg, flc_intf and the finish_line_lap_counter RTL.
`timescale 1ns / 1ps

module finish_line_lap_counter_test;

   localparam int PB = flc_pkg::POS_BITS_DEFAULT;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [flc_pkg::LAP_BITS-1:0] total;
      logic                         crossed;
      logic                         ahead;
   } lap_result_type;

   // one directed row: position plus optional typed-in expectation
   typedef struct {
      int             x;
      int             y;
      bit             typed;
      lap_result_type want;
   } lap_row_type;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [flc_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
   logic [flc_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
   logic [flc_pkg::CFG_DATA_BITS-1:0] prdata;
   logic pready;

   flc_req_intf #(.POS_BITS(PB)) req_bus ();
   flc_rsp_intf rsp_bus ();

   finish_line_lap_counter #(.POS_BITS(PB)) DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // predictor copy of registers and state
   longint left_x, left_y, right_x, right_y, near_rad, cos_lim;
   longint last_x, last_y;
   bit     last_seen, ahead_now;
   int     laps;

   lap_result_type expected_laps[$];
   bit             failed = 0;
   longint         cycles = 0;
   bit             long_stalls = 1;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint iroot(longint unsigned n);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic void to_unit(longint x, longint y, output longint ux, output longint uy);
      longint unsigned ax, ay, m, r;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = ax > ay ? ax : ay;
      if (m == 0) begin
         ux = 0;
         uy = 0;
         return;
      end
      while (m >= 32768) begin
         ax >>= 1; ay >>= 1; m >>= 1;
      end
      while (m < 16384) begin
         ax <<= 1; ay <<= 1; m <<= 1;
      end
      r = iroot(ax * ax + ay * ay);
      ux = longint'((ax << 15) / r);
      uy = longint'((ay << 15) / r);
      if (x < 0) ux = -ux;
      if (y < 0) uy = -uy;
   endfunction

   function automatic lap_result_type predict_lap(longint px, longint py);
      lap_result_type res;
      longint dx, dy, u1x, u1y, u2x, u2y, u3x, u3y, th, d23, d31;
      longint unsigned adx, ady, lim;
      bit crossed = 0;
      if (!last_seen) begin
         last_seen = 1;
         last_x = px;
         last_y = py;
      end else if (px != last_x || py != last_y) begin
         dx = 2 * px - (left_x + right_x);
         dy = 2 * py - (left_y + right_y);
         lim = 2 * near_rad;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         if (adx <= lim && ady <= lim && adx * adx + ady * ady <= lim * lim) begin
            th = cos_lim * 32768;
            to_unit(last_x - px, last_y - py, u1x, u1y);
            to_unit(right_y - left_y, left_x - right_x, u2x, u2y);
            to_unit(dx, dy, u3x, u3y);
            if (u1x * u2x + u1y * u2y > th) begin
               d23 = u2x * u3x + u2y * u3y;
               d31 = u3x * u1x + u3y * u1y;
               if (d23 > th && d31 > th) begin
                  ahead_now = 1;
               end else if (d23 < -th && d31 < -th) begin
                  if (ahead_now) begin
                     crossed = 1;
                     if (laps < 65535) laps++;
                  end
                  ahead_now = 0;
               end else begin
                  ahead_now = 0;
               end
            end
         end
         last_x = px;
         last_y = py;
      end
      res.total = laps[15:0];
      res.crossed = crossed;
      res.ahead = ahead_now;
      return res;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 3) == 0) ? 0 :
          (long_stalls && $urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
          $urandom_range(0, 3);
      repeat (n) @(negedge clock);
   endtask

   task automatic write_reg(flc_pkg::reg_index_type idx, longint value);
      @(negedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= flc_pkg::CFG_ADDR_BITS'(4 * int'(idx));
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      unique case (idx)
         flc_pkg::REG_LEFT_X:       left_x = 64'(signed'(value[23:0]));
         flc_pkg::REG_LEFT_Y:       left_y = 64'(signed'(value[23:0]));
         flc_pkg::REG_RIGHT_X:      right_x = 64'(signed'(value[23:0]));
         flc_pkg::REG_RIGHT_Y:      right_y = 64'(signed'(value[23:0]));
         flc_pkg::REG_NEAR_RADIUS:  near_rad = value & 64'h7FFFFF;
         flc_pkg::REG_COSINE_LIMIT: cos_lim = 64'(signed'(value[15:0]));
         default: ;
      endcase
   endtask

   task automatic send_pos(longint x, longint y, bit typed, lap_result_type want);
      lap_result_type p;
      logic signed [PB-1:0] sx, sy;
      bit rdy;
      idle_gap();
      @(negedge clock);
      sx = PB'(x);
      sy = PB'(y);
      req_bus.valid <= 1;
      req_bus.pos_x <= sx;
      req_bus.pos_y <= sy;
      // ready depends on the sequencer state only; sample it mid-cycle
      do begin
         rdy = req_bus.ready;
         @(posedge clock);
         if (!rdy) @(negedge clock);
      end while (!rdy);
      p = predict_lap(longint'(sx), longint'(sy));
      if (typed && p != want) begin
         $display("%0t directed row disagrees: table %p predictor %p", $time, want, p);
         failed = 1;
      end
      expected_laps.insert(expected_laps.size(), p);
      @(negedge clock);
      req_bus.valid <= 0;
   endtask

   task automatic drain();
      while (expected_laps.size() != 0) @(negedge clock);
      repeat (260) @(negedge clock);
   endtask

   // response side: random back-pressure with a few long stalls, compare on each transfer
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (long_stalls && $urandom_range(0, 99) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0) ||
                             (!long_stalls && $urandom_range(0, 1) == 0);
         end
      end
   end

   always @(posedge clock) begin
      lap_result_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_laps.size() == 0) begin
            $display("%0t unexpected result: actual %0d/%0b/%0b", $time,
                     rsp_bus.lap_total, rsp_bus.lap_crossed, rsp_bus.finish_ahead);
            failed = 1;
         end else begin
            w = expected_laps.pop_front();
            if (w.total !== rsp_bus.lap_total || w.crossed !== rsp_bus.lap_crossed ||
                w.ahead !== rsp_bus.finish_ahead) begin
               $display("%0t mismatch: expected %0d/%0b/%0b actual %0d/%0b/%0b", $time,
                        w.total, w.crossed, w.ahead, rsp_bus.lap_total,
                        rsp_bus.lap_crossed, rsp_bus.finish_ahead);
               failed = 1;
            end
         end
      end
   end

   // lap through a line along x through the origin: from y=-reach toward +y side and back
   task automatic run_laps(int count, longint half_w, longint reach);
      lap_result_type none;
      longint jx;
      for (int k = 0; k < count; k++) begin
         jx = $urandom_range(0, 2 * half_w) - half_w;
         send_pos(jx, -reach, 0, none);
         send_pos(jx + $urandom_range(0, 9) - 4, -reach / 3, 0, none);
         send_pos(jx, reach / 3, 0, none);
         send_pos(jx + $urandom_range(0, 9) - 4, reach, 0, none);
         if ($urandom_range(0, 4) == 0)
            send_pos($urandom_range(0, 200) - 100, $urandom_range(0, 4000) - 2000, 0, none);
      end
   endtask

   lap_row_type rows[$];
   lap_result_type none;

   initial begin
      req_bus.valid = 0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      left_x = 0; left_y = 0; right_x = 0; right_y = 0;
      near_rad = 1280; cos_lim = 16384;
      last_x = 0; last_y = 0; last_seen = 0; ahead_now = 0; laps = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // finish line from (512,0) to (-512,0): normal points to +y
      write_reg(flc_pkg::REG_LEFT_X, 512);
      write_reg(flc_pkg::REG_LEFT_Y, 0);
      write_reg(flc_pkg::REG_RIGHT_X, -512);
      write_reg(flc_pkg::REG_RIGHT_Y, 0);
      write_reg(flc_pkg::REG_NEAR_RADIUS, 1280);
      write_reg(flc_pkg::REG_COSINE_LIMIT, 16384);

      rows = '{
         '{0, -800, 1, '{16'd0, 1'b0, 1'b0}},            // first position: record only
         '{0, -800, 1, '{16'd0, 1'b0, 1'b0}},            // unchanged position
         '{0, 3000, 1, '{16'd0, 1'b0, 1'b0}},            // far from finish
         '{0, 1200, 0, '{16'd0, 1'b0, 1'b0}},
         '{0, 400, 0, '{16'd0, 1'b0, 1'b0}},
         '{0, -400, 0, '{16'd0, 1'b0, 1'b0}},
         '{0, -1200, 0, '{16'd0, 1'b0, 1'b0}},
         '{0, 1200, 0, '{16'd0, 1'b0, 1'b0}},
         '{0, -1200, 0, '{16'd0, 1'b0, 1'b0}},
         '{100, 0, 0, '{16'd0, 1'b0, 1'b0}},             // on the line
         '{-8388608, -8388608, 0, '{16'd0, 1'b0, 1'b0}},
         '{8388607, 8388607, 0, '{16'd0, 1'b0, 1'b0}},
         '{-8388608, 8388607, 0, '{16'd0, 1'b0, 1'b0}},
         '{1, 1, 0, '{16'd0, 1'b0, 1'b0}},
         '{0, 0, 0, '{16'd0, 1'b0, 1'b0}}                // zero-length offset to centre
      };
      foreach (rows[i]) send_pos(rows[i].x, rows[i].y, rows[i].typed, rows[i].want);
      drain();

      // extreme finish points and registers, then a degenerate finish (both points equal)
      write_reg(flc_pkg::REG_LEFT_X, -8388608);
      write_reg(flc_pkg::REG_RIGHT_X, 8388607);
      write_reg(flc_pkg::REG_LEFT_Y, 8388607);
      write_reg(flc_pkg::REG_RIGHT_Y, -8388608);
      write_reg(flc_pkg::REG_NEAR_RADIUS, 8388607);
      write_reg(flc_pkg::REG_COSINE_LIMIT, -32768);
      for (int i = 0; i < 150; i++)
         send_pos($urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF), 0, none);
      drain();
      write_reg(flc_pkg::REG_NEAR_RADIUS, 0);
      write_reg(flc_pkg::REG_COSINE_LIMIT, 32767);
      write_reg(flc_pkg::REG_LEFT_X, 0); write_reg(flc_pkg::REG_RIGHT_X, 0);
      write_reg(flc_pkg::REG_LEFT_Y, 0); write_reg(flc_pkg::REG_RIGHT_Y, 0);
      for (int i = 0; i < 40; i++)
         send_pos($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2, 0, none);
      drain();

      // main phases: laps across several geometries and thresholds
      for (int ph = 0; ph < 6; ph++) begin
         longint hw;
         hw = (ph % 2) ? 300 : 2000;
         long_stalls = (ph != 3);
         write_reg(flc_pkg::REG_LEFT_X, hw);
         write_reg(flc_pkg::REG_LEFT_Y, ph * 7);
         write_reg(flc_pkg::REG_RIGHT_X, -hw);
         write_reg(flc_pkg::REG_RIGHT_Y, -(ph * 7));
         write_reg(flc_pkg::REG_NEAR_RADIUS, hw + 1500);
         write_reg(flc_pkg::REG_COSINE_LIMIT, (ph == 4) ? -1000 : $urandom_range(0, 30000));
         run_laps(55, hw / 2, hw + 600);
         for (int i = 0; i < 40; i++)
            send_pos($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000, 0, none);
         drain();
      end

      // reverse direction: left and right x swapped, which flips the finish normal
      write_reg(flc_pkg::REG_LEFT_X, -1000);
      write_reg(flc_pkg::REG_RIGHT_X, 1000);
      run_laps(25, 400, 1600);
      drain();

      if (!failed)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
